// ----- sv/knob_setpoint_display_formatter_defines.svh -----
// ============================================================================
// Knob setpoint display formatter assertion macros
// Shared assertion forms for the checker of the knob setpoint display block.
// ============================================================================
`ifndef KNOB_SETPOINT_DISPLAY_FORMATTER_DEFINES_SVH
`define KNOB_SETPOINT_DISPLAY_FORMATTER_DEFINES_SVH

// Condition on the same clock edge implies a consequence.
`define KSDF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Condition on one clock edge implies a consequence on the next edge.
`define KSDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ksdf_pkg.sv -----
// ============================================================================
// Knob setpoint display formatter package
// Types and constants shared by the stages of the knob setpoint display block.
// ============================================================================
package ksdf_pkg;

    // Item kinds carried by the mode field.
    typedef enum logic
    {
        MODE_EDGE    = 1'b0,
        MODE_REFRESH = 1'b1
    } mode_t;

    typedef logic [15:0] word_t;
    typedef logic [3:0]  digit_t;
    typedef logic [4:0]  disp_t;

    // Display code for a dark digit.
    localparam disp_t DIGIT_BLANK = 5'h10;

    // Setpoint folding limits.
    localparam logic [7:0] SETPOINT_MAX  = 8'd50;
    localparam logic [7:0] WRAP_NEGATIVE = 8'd128;

    // Reciprocals for exact division of a 16-bit value by powers of ten.
    localparam logic [16:0] RECIP_10    = 17'd52429;   // shift 19
    localparam logic [16:0] RECIP_100   = 17'd83887;   // shift 23
    localparam logic [16:0] RECIP_1000  = 17'd67109;   // shift 26
    localparam logic [16:0] RECIP_10000 = 17'd107375;  // shift 30

    // Values chosen for display, after the state update stage.
    typedef struct packed
    {
        word_t top_value;
        word_t bottom_value;
        logic  battery_low;
    } sel_t;

    // Values with their decimal quotients, after the multiply stage.
    typedef struct packed
    {
        word_t       top_value;
        logic [12:0] top_q1;
        logic [9:0]  top_q2;
        logic [6:0]  top_q3;
        word_t       bottom_value;
        logic [12:0] bottom_q1;
        logic [9:0]  bottom_q2;
        logic [6:0]  bottom_q3;
        logic [2:0]  bottom_q4;
        logic        battery_low;
    } quot_t;

    // One formatted result beat.
    typedef struct packed
    {
        disp_t top_hundreds;
        disp_t top_tens;
        disp_t top_units;
        disp_t bottom_thousands;
        disp_t bottom_hundreds;
        disp_t bottom_tens;
        disp_t bottom_units;
        logic  battery_low;
    } result_t;

endpackage

// ----- sv/ksdf_in_if.sv -----
// ============================================================================
// Knob setpoint display formatter input channel
// Valid/ready channel that carries one edge or refresh beat.
// ============================================================================
interface ksdf_in_if;

    logic        valid;
    logic        ready;
    logic        mode;
    logic [1:0]  wheel_pins;
    logic        left_pressed;
    logic        middle_pressed;
    logic        right_pressed;
    logic [15:0] battery_level;
    logic [15:0] temperature;
    logic [15:0] motor_pos;
    logic [15:0] motor_pct;

    modport source
    (
        output valid, mode, wheel_pins, left_pressed, middle_pressed, right_pressed,
        output battery_level, temperature, motor_pos, motor_pct,
        input  ready
    );

    modport sink
    (
        input  valid, mode, wheel_pins, left_pressed, middle_pressed, right_pressed,
        input  battery_level, temperature, motor_pos, motor_pct,
        output ready
    );

endinterface

// ----- sv/ksdf_out_if.sv -----
// ============================================================================
// Knob setpoint display formatter output channel
// Valid/ready channel that carries one formatted display beat.
// ============================================================================
interface ksdf_out_if;

    logic       valid;
    logic       ready;
    logic [4:0] top_hundreds;
    logic [4:0] top_tens;
    logic [4:0] top_units;
    logic [4:0] bottom_thousands;
    logic [4:0] bottom_hundreds;
    logic [4:0] bottom_tens;
    logic [4:0] bottom_units;
    logic       battery_low;

    modport source
    (
        output valid, top_hundreds, top_tens, top_units,
        output bottom_thousands, bottom_hundreds, bottom_tens, bottom_units,
        output battery_low,
        input  ready
    );

    modport sink
    (
        input  valid, top_hundreds, top_tens, top_units,
        input  bottom_thousands, bottom_hundreds, bottom_tens, bottom_units,
        input  battery_low,
        output ready
    );

endinterface

// ----- sv/ksdf_front.sv -----
// ============================================================================
// Knob setpoint display formatter front stage
// Tracks the knob, folds it into the setpoint and picks the values to show.
// ============================================================================
module ksdf_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    ksdf_in_if.sink        in_ch,
    output logic           dn_valid,
    output ksdf_pkg::sel_t dn_data,
    input  logic           dn_ready
);
    import ksdf_pkg::*;

    logic [15:0] threshold_reg;
    logic [7:0]  knob_count_reg;
    logic [7:0]  knob_count_next;
    logic [7:0]  applied_count_reg;
    logic [1:0]  previous_pins_reg;
    logic [1:0]  previous_pins_next;
    logic [5:0]  setpoint_reg;
    logic [5:0]  setpoint_next;
    logic        sel_valid_reg;
    sel_t        sel_reg;
    sel_t        sel_next;
    logic        accept;
    logic        is_refresh;
    logic [7:0]  diff;
    logic [7:0]  folded;

    // The stage takes a beat whenever its register is empty or draining.
    assign in_ch.ready = !sel_valid_reg || dn_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_refresh  = (in_ch.mode == MODE_REFRESH);

    // Quadrature step on a change of the pins: count up when A and B differ, down when they match.
    always_comb
    begin
        knob_count_next    = knob_count_reg;
        previous_pins_next = previous_pins_reg;
        if (in_ch.wheel_pins != previous_pins_reg)
        begin
            previous_pins_next = in_ch.wheel_pins;
            if (in_ch.wheel_pins[0] ^ in_ch.wheel_pins[1])
                knob_count_next = knob_count_reg + 8'd1;
            else
                knob_count_next = knob_count_reg - 8'd1;
        end
    end

    // Fold twice the signed movement into the setpoint and clamp it to 0..50.
    always_comb
    begin
        diff   = knob_count_reg - applied_count_reg;
        folded = {2'b00, setpoint_reg} + {diff[6:0], 1'b0};
        if (folded > WRAP_NEGATIVE)
            setpoint_next = 6'd0;
        else if (folded > SETPOINT_MAX)
            setpoint_next = SETPOINT_MAX[5:0];
        else
            setpoint_next = folded[5:0];
    end

    // Source selection for both rows and the battery flag.
    always_comb
    begin
        if (in_ch.left_pressed)
            sel_next.top_value = in_ch.battery_level;
        else if (in_ch.right_pressed)
            sel_next.top_value = in_ch.temperature;
        else
            sel_next.top_value = {10'd0, setpoint_next};
        sel_next.bottom_value = in_ch.middle_pressed ? in_ch.motor_pos : in_ch.motor_pct;
        sel_next.battery_low  = (in_ch.battery_level < threshold_reg);
    end

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= 16'd0;
        else if (cfg_wr_en)
            threshold_reg <= cfg_wr_data;
    end

    // Knob and setpoint state, updated as each beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_count_reg    <= 8'd0;
            applied_count_reg <= 8'd0;
            previous_pins_reg <= 2'd0;
            setpoint_reg      <= 6'd0;
        end
        else if (accept)
        begin
            if (is_refresh)
            begin
                applied_count_reg <= knob_count_reg;
                setpoint_reg      <= setpoint_next;
            end
            else
            begin
                knob_count_reg    <= knob_count_next;
                previous_pins_reg <= previous_pins_next;
            end
        end
    end

    // Stage register: only refresh beats move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else if (in_ch.ready)
            sel_valid_reg <= accept && is_refresh;
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_refresh)
            sel_reg <= sel_next;
    end

    assign dn_valid = sel_valid_reg;
    assign dn_data  = sel_reg;

endmodule

// ----- sv/ksdf_divide.sv -----
// ============================================================================
// Knob setpoint display formatter quotient stage
// Divides both row values by powers of ten with reciprocal multiplies.
// ============================================================================
module ksdf_divide
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  ksdf_pkg::sel_t  up_data,
    output logic            up_ready,
    output logic            dn_valid,
    output ksdf_pkg::quot_t dn_data,
    input  logic            dn_ready
);
    import ksdf_pkg::*;

    logic  quot_valid_reg;
    quot_t quot_reg;
    quot_t quot_next;

    // Exact for every 16-bit value: the reciprocal error stays below one step.
    function automatic logic [32:0] scale(input word_t v, input logic [16:0] recip);
        scale = {17'd0, v} * {16'd0, recip};
    endfunction

    // Quotients by 10, 100, 1000 and 10000; the products run in parallel.
    always_comb
    begin
        logic [32:0] t10;
        logic [32:0] t100;
        logic [32:0] t1000;
        logic [32:0] b10;
        logic [32:0] b100;
        logic [32:0] b1000;
        logic [32:0] b10000;
        t10    = scale(up_data.top_value, RECIP_10);
        t100   = scale(up_data.top_value, RECIP_100);
        t1000  = scale(up_data.top_value, RECIP_1000);
        b10    = scale(up_data.bottom_value, RECIP_10);
        b100   = scale(up_data.bottom_value, RECIP_100);
        b1000  = scale(up_data.bottom_value, RECIP_1000);
        b10000 = scale(up_data.bottom_value, RECIP_10000);
        quot_next.top_value    = up_data.top_value;
        quot_next.top_q1       = t10[31:19];
        quot_next.top_q2       = t100[32:23];
        quot_next.top_q3       = t1000[32:26];
        quot_next.bottom_value = up_data.bottom_value;
        quot_next.bottom_q1    = b10[31:19];
        quot_next.bottom_q2    = b100[32:23];
        quot_next.bottom_q3    = b1000[32:26];
        quot_next.bottom_q4    = b10000[32:30];
        quot_next.battery_low  = up_data.battery_low;
    end

    assign up_ready = !quot_valid_reg || dn_ready;

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quot_valid_reg <= 1'b0;
        else if (up_ready)
            quot_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            quot_reg <= quot_next;
    end

    assign dn_valid = quot_valid_reg;
    assign dn_data  = quot_reg;

endmodule

// ----- sv/ksdf_digits.sv -----
// ============================================================================
// Knob setpoint display formatter digit stage
// Splits quotients into decimal digits, blanks leading zeros, holds the result.
// ============================================================================
module ksdf_digits
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  ksdf_pkg::quot_t   up_data,
    output logic              up_ready,
    output logic              dn_valid,
    output ksdf_pkg::result_t dn_data,
    input  logic              dn_ready
);
    import ksdf_pkg::*;

    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    // Digit from a value and its quotient by ten: a - 10 * b.
    function automatic digit_t low_digit(input word_t a, input word_t b);
        word_t ten_b;
        ten_b     = {b[12:0], 3'b000} + {b[14:0], 1'b0};
        low_digit = 4'((a - ten_b) & 16'h000F);
    endfunction

    function automatic disp_t shown(input digit_t d);
        shown = {1'b0, d};
    endfunction

    // Digit extraction and leading-zero blanking for both rows.
    always_comb
    begin
        digit_t th;
        digit_t tt;
        digit_t tu;
        digit_t bth;
        digit_t bh;
        digit_t bt;
        digit_t bu;
        th  = low_digit({6'd0, up_data.top_q2}, {9'd0, up_data.top_q3});
        tt  = low_digit({3'd0, up_data.top_q1}, {6'd0, up_data.top_q2});
        tu  = low_digit(up_data.top_value, {3'd0, up_data.top_q1});
        bth = low_digit({9'd0, up_data.bottom_q3}, {13'd0, up_data.bottom_q4});
        bh  = low_digit({6'd0, up_data.bottom_q2}, {9'd0, up_data.bottom_q3});
        bt  = low_digit({3'd0, up_data.bottom_q1}, {6'd0, up_data.bottom_q2});
        bu  = low_digit(up_data.bottom_value, {3'd0, up_data.bottom_q1});

        // Top row: only the hundreds digit can go dark.
        res_next.top_hundreds = (th == 4'd0) ? DIGIT_BLANK : shown(th);
        res_next.top_tens     = shown(tt);
        res_next.top_units    = shown(tu);

        // Bottom row: a digit other than the units is dark when it and every digit to its left are zero.
        res_next.bottom_thousands = (bth == 4'd0) ? DIGIT_BLANK : shown(bth);
        res_next.bottom_hundreds  = (bth == 4'd0 && bh == 4'd0) ? DIGIT_BLANK : shown(bh);
        res_next.bottom_tens      = (bth == 4'd0 && bh == 4'd0 && bt == 4'd0) ?
                                    DIGIT_BLANK : shown(bt);
        res_next.bottom_units     = shown(bu);
        res_next.battery_low      = up_data.battery_low;
    end

    assign up_ready = !res_valid_reg || dn_ready;

    // Result register that faces the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (up_ready)
            res_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            res_reg <= res_next;
    end

    assign dn_valid = res_valid_reg;
    assign dn_data  = res_reg;

endmodule

// ----- sv/knob_setpoint_display_formatter.sv -----
// Knob setpoint display formatter. Takes one beat per clock on in_ch, edge or
// refresh, while the pipeline is not stalled: each of the three register
// stages (knob state and source select, reciprocal multiplies, digit split and
// blanking) moves on whenever the stage ahead of it is empty or draining, so a
// stalled out_ch backs up to in_ch. An edge beat updates the knob counter as
// it is taken and yields no result. A refresh beat yields one result beat on
// out_ch once it has passed the select, quotient and result registers in turn.
// The user must write the battery threshold through cfg_wr_en/cfg_wr_data
// only while no beat is in flight; the block itself does not enforce this.
// ============================================================================
// Knob setpoint display formatter
// Quadrature knob setpoint tracking with two-row decimal display formatting.
// ============================================================================
module knob_setpoint_display_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    ksdf_in_if.sink     in_ch,
    ksdf_out_if.source  out_ch
);
    import ksdf_pkg::*;

    logic    sel_valid;
    sel_t    sel_data;
    logic    sel_ready;
    logic    quot_valid;
    quot_t   quot_data;
    logic    quot_ready;
    result_t res_data;

    // Knob state, setpoint and source selection.
    ksdf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .dn_valid    (sel_valid),
        .dn_data     (sel_data),
        .dn_ready    (sel_ready)
    );

    // Decimal quotients of both row values.
    ksdf_divide u_divide
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sel_valid),
        .up_data  (sel_data),
        .up_ready (sel_ready),
        .dn_valid (quot_valid),
        .dn_data  (quot_data),
        .dn_ready (quot_ready)
    );

    // Digits, blanking and the output register.
    ksdf_digits u_digits
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (quot_valid),
        .up_data  (quot_data),
        .up_ready (quot_ready),
        .dn_valid (out_ch.valid),
        .dn_data  (res_data),
        .dn_ready (out_ch.ready)
    );

    // Result fields onto the output channel.
    assign out_ch.top_hundreds     = res_data.top_hundreds;
    assign out_ch.top_tens         = res_data.top_tens;
    assign out_ch.top_units        = res_data.top_units;
    assign out_ch.bottom_thousands = res_data.bottom_thousands;
    assign out_ch.bottom_hundreds  = res_data.bottom_hundreds;
    assign out_ch.bottom_tens      = res_data.bottom_tens;
    assign out_ch.bottom_units     = res_data.bottom_units;
    assign out_ch.battery_low      = res_data.battery_low;

endmodule

// ----- sv/ksdf_checker.sv -----
// ============================================================================
// Knob setpoint display formatter checker
// Port-level checks on the formatted output, bound to the top level.
// ============================================================================
`include "knob_setpoint_display_formatter_defines.svh"

module ksdf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] top_hundreds,
    input logic [4:0] top_tens,
    input logic [4:0] top_units,
    input logic [4:0] bottom_thousands,
    input logic [4:0] bottom_hundreds,
    input logic [4:0] bottom_tens,
    input logic [4:0] bottom_units
);
    import ksdf_pkg::*;

    // The middle top digit and both units digits are always lit.
    `KSDF_ASSERT_NOW(a_lit_digits, clk, rst_n, out_valid, top_tens <= 5'd9 && top_units <= 5'd9 && bottom_units <= 5'd9, "lit digit out of range")

    // Blanking runs from the left: a dark digit has only dark digits before it.
    `KSDF_ASSERT_NOW(a_blank_order, clk, rst_n, out_valid, (bottom_hundreds != DIGIT_BLANK || bottom_thousands == DIGIT_BLANK) && (bottom_tens != DIGIT_BLANK || bottom_hundreds == DIGIT_BLANK), "blanking out of order")

    // The top hundreds digit is a decimal digit or dark; neither leading digit is ever a lit zero.
    `KSDF_ASSERT_NOW(a_lead_codes, clk, rst_n, out_valid, (top_hundreds <= 5'd9 || top_hundreds == DIGIT_BLANK) && top_hundreds != 5'd0 && bottom_thousands != 5'd0, "bad leading digit code")

    // A stalled result beat stays on the channel with both units digits unchanged.
    `KSDF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bottom_units) && $stable(top_units), "stalled beat changed")

endmodule

bind knob_setpoint_display_formatter ksdf_checker u_ksdf_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .top_hundreds     (out_ch.top_hundreds),
    .top_tens         (out_ch.top_tens),
    .top_units        (out_ch.top_units),
    .bottom_thousands (out_ch.bottom_thousands),
    .bottom_hundreds  (out_ch.bottom_hundreds),
    .bottom_tens      (out_ch.bottom_tens),
    .bottom_units     (out_ch.bottom_units)
);

// ----- test/ksdf_display_checker.sv -----
// ============================================================================
// Knob setpoint display formatter checker
// Watches both channels and the threshold port, predicts each display beat
// from its own copy of the knob state, and compares results in order.
// ============================================================================
`timescale 1ns / 100ps

module ksdf_display_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    ksdf_in_if          in_mon,
    ksdf_out_if         out_mon,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);
    import ksdf_pkg::*;

    // Shadow of the block's knob state and battery threshold.
    logic [7:0] knob_pos;
    logic [7:0] knob_applied;
    logic [1:0] last_pins;
    logic [5:0] setpoint_now;
    word_t      threshold_now;

    // Display beats predicted but not yet seen on the output.
    result_t    display_queue[$];

    // Scratch values for the refresh prediction.
    logic [7:0] turn_delta;
    logic [7:0] folded_sum;
    word_t      top_source;
    word_t      bottom_source;

    // Split the two rows into decimal digits with leading zeros dark.
    function automatic result_t format_display(input word_t top_val, input word_t bot_val,
                                               input logic low_flag);
        result_t     shown;
        int unsigned top_mod;
        int unsigned bot_mod;
        int unsigned d3;
        int unsigned d2;
        int unsigned d1;
        top_mod = top_val % 1000;
        bot_mod = bot_val % 10000;
        d3 = bot_mod / 1000;
        d2 = (bot_mod / 100) % 10;
        d1 = (bot_mod / 10) % 10;
        // The top middle digit always shows, so only the hundreds can go dark.
        shown.top_hundreds = (top_mod / 100 == 0) ? DIGIT_BLANK : disp_t'(top_mod / 100);
        shown.top_tens     = disp_t'((top_mod / 10) % 10);
        shown.top_units    = disp_t'(top_mod % 10);
        shown.bottom_thousands = (d3 == 0) ? DIGIT_BLANK : disp_t'(d3);
        shown.bottom_hundreds  = (d3 == 0 && d2 == 0) ? DIGIT_BLANK : disp_t'(d2);
        shown.bottom_tens      = (d3 == 0 && d2 == 0 && d1 == 0) ? DIGIT_BLANK : disp_t'(d1);
        shown.bottom_units     = disp_t'(bot_mod % 10);
        shown.battery_low      = low_flag;
        return shown;
    endfunction

    // Compare one output beat against the oldest prediction.
    task automatic check_display_beat();
        result_t    seen;
        result_t    want;
        logic [7:0] bad_fields;
        seen.top_hundreds     = out_mon.top_hundreds;
        seen.top_tens         = out_mon.top_tens;
        seen.top_units        = out_mon.top_units;
        seen.bottom_thousands = out_mon.bottom_thousands;
        seen.bottom_hundreds  = out_mon.bottom_hundreds;
        seen.bottom_tens      = out_mon.bottom_tens;
        seen.bottom_units     = out_mon.bottom_units;
        seen.battery_low      = out_mon.battery_low;
        results_checked++;
        if (display_queue.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] display beat arrived with no refresh pending", $time);
        end
        else
        begin
            want = display_queue.pop_front();
            bad_fields = {want.top_hundreds !== seen.top_hundreds,
                          want.top_tens !== seen.top_tens,
                          want.top_units !== seen.top_units,
                          want.bottom_thousands !== seen.bottom_thousands,
                          want.bottom_hundreds !== seen.bottom_hundreds,
                          want.bottom_tens !== seen.bottom_tens,
                          want.bottom_units !== seen.bottom_units,
                          want.battery_low !== seen.battery_low};
            if (bad_fields != 8'd0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] display mismatch, fields %b: expected top %0d %0d %0d ",
                             $time, bad_fields, want.top_hundreds, want.top_tens,
                             want.top_units, "bottom %0d %0d %0d %0d low %0d, ",
                             want.bottom_thousands, want.bottom_hundreds, want.bottom_tens,
                             want.bottom_units, want.battery_low,
                             "got top %0d %0d %0d bottom %0d %0d %0d %0d low %0d",
                             seen.top_hundreds, seen.top_tens, seen.top_units,
                             seen.bottom_thousands, seen.bottom_hundreds, seen.bottom_tens,
                             seen.bottom_units, seen.battery_low);
            end
        end
    endtask

    // Track the knob on every accepted beat and predict each refresh.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_pos        = '0;
            knob_applied    = '0;
            last_pins       = '0;
            setpoint_now    = '0;
            threshold_now   = '0;
            fail_count      = 0;
            outstanding     = 0;
            results_checked = 0;
            display_queue.delete();
        end
        else
        begin
            if (cfg_wr_en)
                threshold_now = cfg_wr_data;

            // A result always lags its refresh, so check first.
            if (out_mon.valid && out_mon.ready)
                check_display_beat();

            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.mode == MODE_EDGE)
                begin
                    // A repeated pin pattern is no movement at all.
                    if (in_mon.wheel_pins != last_pins)
                    begin
                        if (in_mon.wheel_pins[0] ^ in_mon.wheel_pins[1])
                            knob_pos = knob_pos + 8'd1;
                        else
                            knob_pos = knob_pos - 8'd1;
                        last_pins = in_mon.wheel_pins;
                    end
                end
                else
                begin
                    // Fold twice the signed movement into the setpoint, mod 256.
                    turn_delta   = knob_pos - knob_applied;
                    folded_sum   = {2'b00, setpoint_now} + {turn_delta[6:0], 1'b0};
                    knob_applied = knob_pos;
                    if (folded_sum > WRAP_NEGATIVE)
                        folded_sum = 8'd0;
                    else if (folded_sum > SETPOINT_MAX)
                        folded_sum = SETPOINT_MAX;
                    setpoint_now = folded_sum[5:0];

                    // Left wins over right on the top row.
                    if (in_mon.left_pressed)
                        top_source = in_mon.battery_level;
                    else if (in_mon.right_pressed)
                        top_source = in_mon.temperature;
                    else
                        top_source = {10'd0, setpoint_now};
                    bottom_source = in_mon.middle_pressed ? in_mon.motor_pos : in_mon.motor_pct;

                    display_queue.push_back(format_display(top_source, bottom_source,
                                            in_mon.battery_level < threshold_now));
                end
            end
            outstanding = display_queue.size();
        end
    end

endmodule

// ----- test/tb_knob_setpoint_display_formatter.sv -----
// ============================================================================
// Knob setpoint display formatter testbench
// Drives knob turns and display refreshes in bursts against a stalling
// display side, steps the battery threshold between phases, and reports
// the checker's verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb_knob_setpoint_display_formatter;

    import ksdf_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int PHASE_COUNT = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int fail_count;
    int outstanding;
    int results_checked;

    // Sender bookkeeping.
    logic [1:0] pins_now = 2'b00;
    word_t      threshold_set = '0;
    int         edges_sent = 0;
    int         repeats_sent = 0;
    int         refreshes_sent = 0;
    int         threshold_writes = 0;
    int         burst_left = 0;
    bit         gaps_off = 1'b0;

    // Long output hold-off, ordered by the sender and timed by the receiver.
    int         stall_orders = 0;
    int         stall_length = 0;

    ksdf_in_if  in_ch();
    ksdf_out_if out_ch();

    knob_setpoint_display_formatter DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    ksdf_display_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_checked(results_checked)
    );

    always #5 clk = ~clk;

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Display side: a random stall pattern, picked anew when the last one runs out.
    initial
    begin : display_side
        int hold_left = 0;
        int orders_seen = 0;
        int pattern_sel = 0;
        int pattern_left = 0;
        int tick = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (orders_seen != stall_orders)
            begin
                orders_seen = stall_orders;
                hold_left = stall_length;
            end
            if (pattern_left == 0)
            begin
                pattern_sel = $urandom_range(0, 4);
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else
            begin
                case (pattern_sel)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = 1'($urandom_range(0, 1));
                    2:       out_ch.ready = ($urandom_range(0, 9) != 0);
                    3:       out_ch.ready = ($urandom_range(0, 4) == 0);
                    default: out_ch.ready = (tick % 3 == 0);
                endcase
            end
        end
    end

    // Drop valid for a number of cycles.
    task automatic idle_for(input int cycles);
        in_ch.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Bursts of beats with random gaps, unless gaps are switched off.
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!gaps_off)
                idle_for($urandom_range(0, 9));
        end
        burst_left--;
    endtask

    // Hold the beat until the block takes it; returns at a falling edge.
    task automatic offer_beat();
        in_ch.valid = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Let every prediction drain, then keep valid low so the pipeline clears too.
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_threshold(input word_t value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        threshold_set = value;
        threshold_writes++;
    endtask

    // Edge beat; the refresh fields carry noise the block must ignore.
    task automatic send_edge(input logic [1:0] pins);
        pace_sender();
        in_ch.mode = MODE_EDGE;
        in_ch.wheel_pins = pins;
        in_ch.left_pressed = 1'($urandom_range(0, 1));
        in_ch.middle_pressed = 1'($urandom_range(0, 1));
        in_ch.right_pressed = 1'($urandom_range(0, 1));
        in_ch.battery_level = word_t'($urandom_range(0, 65535));
        in_ch.temperature = word_t'($urandom_range(0, 65535));
        in_ch.motor_pos = word_t'($urandom_range(0, 65535));
        in_ch.motor_pct = word_t'($urandom_range(0, 65535));
        offer_beat();
        if (pins != pins_now)
        begin
            edges_sent++;
            pins_now = pins;
        end
        else
            repeats_sent++;
    endtask

    task automatic send_refresh(input logic left, input logic middle, input logic right,
                                input word_t battery, input word_t temp,
                                input word_t pos, input word_t pct);
        pace_sender();
        in_ch.mode = MODE_REFRESH;
        in_ch.wheel_pins = 2'($urandom_range(0, 3));
        in_ch.left_pressed = left;
        in_ch.middle_pressed = middle;
        in_ch.right_pressed = right;
        in_ch.battery_level = battery;
        in_ch.temperature = temp;
        in_ch.motor_pos = pos;
        in_ch.motor_pct = pct;
        offer_beat();
        refreshes_sent++;
    endtask

    // Readings weighted toward digit boundaries and short numbers.
    function automatic word_t pick_reading();
        int unsigned corners[10] = '{9, 10, 99, 100, 999, 1000, 1009, 9999, 10000, 10010};
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return word_t'($urandom_range(0, 9));
            3:       return word_t'($urandom_range(0, 99));
            4:       return word_t'($urandom_range(0, 999));
            5:       return word_t'(corners[$urandom_range(0, 9)]);
            default: return word_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Battery readings land on and around the threshold a good part of the time.
    function automatic word_t pick_battery();
        if ($urandom_range(0, 9) < 3)
            return threshold_set + word_t'($urandom_range(0, 2)) - 16'd1;
        return pick_reading();
    endfunction

    task automatic send_random_refresh();
        send_refresh(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     pick_battery(), pick_reading(), pick_reading(), pick_reading());
    endtask

    // Next pin pattern that moves the count up (pins differ) or down (pins equal).
    function automatic logic [1:0] next_detent(input logic [1:0] cur, input bit up);
        if (up)
            return (cur == 2'b01) ? 2'b10 : (cur == 2'b10) ? 2'b01 :
                   ($urandom_range(0, 1) ? 2'b01 : 2'b10);
        return (cur == 2'b00) ? 2'b11 : (cur == 2'b11) ? 2'b00 :
               ($urandom_range(0, 1) ? 2'b00 : 2'b11);
    endfunction

    initial
    begin : stimulus
        int  phase;
        int  phase_goal;
        int  phase_start;
        int  pick;
        int  run_len;
        bit  up;
        bit  stall_done;
        bit  drain_done;
        word_t phase_threshold[4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};

        stall_done = 1'b0;
        drain_done = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_EDGE;
        in_ch.wheel_pins = '0;
        in_ch.left_pressed = 1'b0;
        in_ch.middle_pressed = 1'b0;
        in_ch.right_pressed = 1'b0;
        in_ch.battery_level = '0;
        in_ch.temperature = '0;
        in_ch.motor_pos = '0;
        in_ch.motor_pct = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: setpoint at zero, blanking corners, repeated pins ignored.
        send_refresh(1'b0, 1'b0, 1'b0, 16'd5, 16'd7, 16'd3, 16'd0);
        send_edge(2'b00);
        send_edge(2'b01);
        send_edge(2'b10);
        send_edge(2'b10);
        send_refresh(1'b0, 1'b1, 1'b1, 16'd0, 16'd999, 16'd9999, 16'd1);
        send_refresh(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_refresh(1'b0, 1'b0, 1'b1, 16'd0, 16'd1000, 16'd0, 16'd10000);
        // Turning back past zero wraps the sum high and clamps to zero.
        send_edge(2'b11);
        send_edge(2'b00);
        send_edge(2'b11);
        send_refresh(1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd100, 16'd0);
        send_refresh(1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd10);

        // Threshold extremes: strictly-below comparison on both sides.
        write_threshold(16'hFFFF);
        send_refresh(1'b1, 1'b0, 1'b0, 16'hFFFE, 16'd0, 16'd0, 16'd99);
        send_refresh(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd999);
        send_refresh(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd1000);
        write_threshold(16'd1);
        send_refresh(1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd1009, 16'd0);
        send_refresh(1'b0, 1'b1, 1'b0, 16'd1, 16'd0, 16'd10010, 16'd0);

        // Random phases, each under its own threshold.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase < 4)
                write_threshold(phase_threshold[phase]);
            else
                write_threshold(word_t'($urandom_range(0, 65535)));
            phase_start = edges_sent + refreshes_sent;
            phase_goal = phase_start + ITEM_TARGET / PHASE_COUNT;
            while (edges_sent + refreshes_sent < phase_goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    gaps_off = !gaps_off;

                // Hold the display side off while refreshes keep coming.
                if (phase == 2 && !stall_done && edges_sent + refreshes_sent > phase_start + 50)
                begin
                    stall_length = 400;
                    stall_orders++;
                    gaps_off = 1'b1;
                    repeat (60) send_random_refresh();
                    stall_done = 1'b1;
                end

                // Pause the sender until every display beat is back.
                if (phase == 3 && !drain_done && edges_sent + refreshes_sent > phase_start + 100)
                begin
                    in_ch.valid = 1'b0;
                    while (outstanding != 0)
                        @(negedge clk);
                    drain_done = 1'b1;
                end

                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // A turn of the knob in one direction, then a refresh.
                    pick = $urandom_range(0, 99);
                    run_len = (pick < 80) ? $urandom_range(0, 4) :
                              (pick < 95) ? $urandom_range(5, 30) : $urandom_range(60, 140);
                    up = 1'($urandom_range(0, 1));
                    repeat (run_len) send_edge(next_detent(pins_now, up));
                    send_random_refresh();
                end
                else if (pick < 85)
                    send_edge(2'($urandom_range(0, 3)));
                else
                    send_random_refresh();
            end
        end

        // Drain and give the verdict.
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Run covered %0d knob edges (%0d repeated pin beats), %0d refreshes, %0d %s",
                 edges_sent, repeats_sent, refreshes_sent, threshold_writes,
                 "threshold writes.");
        $display("%0d display beats checked, including a %0d-cycle display-side hold-off.",
                 results_checked, stall_length);
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
